[rtl/core/bgd_pkg.sv]
package bgd_pkg;

  localparam int NUM_BUTTONS = 8;

  localparam int IDX_W   = 3;
  localparam int CMD_W   = 2;
  localparam int STEP_W  = 3;
  localparam int CNT_W   = 16;
  localparam int SHORT_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Gesture steps.
  localparam logic [STEP_W-1:0] STEP_START      = 3'd0;
  localparam logic [STEP_W-1:0] STEP_PRESSED    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LONG_HELD  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_WAIT_PRESS = 3'd3;
  localparam logic [STEP_W-1:0] STEP_WAIT_REL   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_END        = 3'd5;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOUBLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LONG   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DCLICK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

  localparam logic [SHORT_W-1:0] DEBOUNCE_RESET = 8'd5;
  localparam logic [SHORT_W-1:0] DCLICK_RESET   = 8'd50;
  localparam logic [CNT_W-1:0]   LONG_RESET     = 16'd200;

  typedef struct packed {
    logic [SHORT_W-1:0] debounce_ticks;
    logic [SHORT_W-1:0] double_click_ticks;
    logic [CNT_W-1:0]   long_push_ticks;
  } cfg_t;

  typedef struct packed {
    logic              last_level;
    logic [STEP_W-1:0] gesture_step;
    logic [CNT_W-1:0]  tick_count;
  } btn_t;

endpackage

[rtl/core/button_gesture_decoder_top.sv]
// Button gesture decoder. Each transfer on the input channel is one sampling
// tick (button index and raw level) and produces exactly one result transfer
// carrying the same index and a command: none, click, double click or long
// push. One item is accepted every cycle while the result side is not stalled;
// an item passes through the input register, then the result register, and
// per-button state is updated as the item moves into the result register, so
// back-to-back ticks for the same button need no extra forwarding. Per-button
// state lives in flip-flops and is cleared by reset. Thresholds must be written
// through the configuration port while no items are in flight; the block itself does not enforce it.
module button_gesture_decoder_top
  import bgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IDX_W-1:0]      button_index,
  input  logic                  level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      button_id,
  output logic [CMD_W-1:0]      command
);

  cfg_t             cfg;
  btn_t             btn [NUM_BUTTONS];
  btn_t             cur;
  btn_t             nxt;
  logic             hit;
  logic [CMD_W-1:0] step_cmd;

  logic             hold_valid;
  logic [IDX_W-1:0] hold_index;
  logic             hold_level;
  logic             advance;

  bgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_index <= button_index;
      hold_level <= level;
    end
  end

  // Select the addressed button; an index beyond the last button finds none.
  always_comb begin
    cur = '0;
    hit = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (hold_index == IDX_W'(i)) begin
        cur = btn[i];
        hit = 1'b1;
      end
    end
  end

  bgd_step u_step (
    .cfg (cfg),
    .cur (cur),
    .lv  (hold_level),
    .nxt (nxt),
    .cmd (step_cmd)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (rst) begin
        btn[i] <= '0;
      end else if (advance && hit && hold_index == IDX_W'(i)) begin
        btn[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      button_id <= hold_index;
      command   <= hit ? step_cmd : CMD_NONE;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!hold_valid && !out_valid))
    else $error("pipeline not empty after reset");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !out_valid) |-> in_ready)
    else $error("input stalled with an empty result register");

  a_cmd_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && command != CMD_NONE) |-> (int'(button_id) < NUM_BUTTONS))
    else $error("command reported for a nonexistent button");

endmodule

[rtl/core/bgd_cfg.sv]
module bgd_cfg
  import bgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.double_click_ticks <= DCLICK_RESET;
      cfg.long_push_ticks    <= LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_ticks     <= cfg_data[SHORT_W-1:0];
        REG_DCLICK:   cfg.double_click_ticks <= cfg_data[SHORT_W-1:0];
        REG_LONG:     cfg.long_push_ticks    <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/bgd_step.sv]
module bgd_step
  import bgd_pkg::*;
(
  input  cfg_t             cfg,
  input  btn_t             cur,
  input  logic             lv,
  output btn_t             nxt,
  output logic [CMD_W-1:0] cmd
);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] inc;
  logic             hit_db;
  logic             hit_dc;
  logic             hit_lp;

  // A level change restarts the counter before any threshold is checked.
  assign cnt    = (cur.last_level != lv) ? '0 : cur.tick_count;
  assign inc    = cnt + CNT_W'(1);
  assign hit_db = (cnt == {{(CNT_W-SHORT_W){1'b0}}, cfg.debounce_ticks});
  assign hit_dc = (cnt == {{(CNT_W-SHORT_W){1'b0}}, cfg.double_click_ticks});
  assign hit_lp = (cnt == cfg.long_push_ticks);

  always_comb begin
    nxt.last_level   = lv;
    nxt.gesture_step = cur.gesture_step;
    nxt.tick_count   = cnt;
    cmd              = CMD_NONE;
    unique case (cur.gesture_step)
      STEP_START: begin
        if (lv) begin
          nxt.tick_count = inc;
          if (hit_db) nxt.gesture_step = STEP_PRESSED;
        end
      end
      STEP_PRESSED: begin
        nxt.tick_count = inc;
        if (lv) begin
          if (hit_lp) begin
            nxt.gesture_step = STEP_LONG_HELD;
            cmd              = CMD_LONG;
          end
        end else if (hit_db) begin
          nxt.gesture_step = STEP_WAIT_PRESS;
        end
      end
      STEP_LONG_HELD: begin
        // While held the counter is left alone and long push repeats.
        if (lv) begin
          cmd = CMD_LONG;
        end else begin
          nxt.tick_count = inc;
          if (hit_db) nxt.gesture_step = STEP_END;
        end
      end
      STEP_WAIT_PRESS: begin
        nxt.tick_count = inc;
        if (lv) begin
          if (hit_db) nxt.gesture_step = STEP_WAIT_REL;
        end else if (hit_dc) begin
          nxt.gesture_step = STEP_END;
          cmd              = CMD_CLICK;
        end
      end
      STEP_WAIT_REL: begin
        if (!lv) begin
          nxt.tick_count = inc;
          if (hit_db) begin
            nxt.gesture_step = STEP_END;
            cmd              = CMD_DOUBLE;
          end
        end
      end
      default: begin
        // End step and the unused codes go back to start.
        nxt.gesture_step = STEP_START;
        nxt.tick_count   = '0;
      end
    endcase
  end

endmodule

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bgd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF    = 300;

  typedef struct packed {
    logic [IDX_W-1:0] id;
    logic [CMD_W-1:0] cmd;
  } gesture_t;

  // Per-button gesture tracker: mirrors the thresholds and the per-button state,
  // and keeps the commands that are still due on the result channel.
  class gesture_tracker;
    logic [SHORT_W-1:0] debounce;
    logic [SHORT_W-1:0] dclick;
    logic [CNT_W-1:0]   long_lim;
    logic               last_lv [NUM_BUTTONS];
    logic [STEP_W-1:0]  step    [NUM_BUTTONS];
    logic [CNT_W-1:0]   cnt     [NUM_BUTTONS];
    gesture_t           due_commands[$];
    int                 errors;
    int                 checked;
    int                 cmd_seen[4];

    function new();
      debounce = DEBOUNCE_RESET;
      dclick   = DCLICK_RESET;
      long_lim = LONG_RESET;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        last_lv[i] = 1'b0;
        step[i]    = STEP_START;
        cnt[i]     = '0;
      end
      errors  = 0;
      checked = 0;
      for (int i = 0; i < 4; i++) cmd_seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE: debounce = data[SHORT_W-1:0];
        REG_DCLICK:   dclick   = data[SHORT_W-1:0];
        REG_LONG:     long_lim = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // The comparison uses the count before it advances; the count wraps at 16 bits.
    function bit count_reaches(logic [IDX_W-1:0] b, logic [CNT_W-1:0] lim);
      bit hit;
      hit = (cnt[b] == lim);
      cnt[b] = cnt[b] + 1'b1;
      return hit;
    endfunction

    function void note_tick(logic [IDX_W-1:0] b, logic lv);
      gesture_t due;
      due.id  = b;
      due.cmd = CMD_NONE;
      if (int'(b) < NUM_BUTTONS) begin
        if (last_lv[b] != lv) begin
          last_lv[b] = lv;
          cnt[b] = '0;
        end
        case (step[b])
          STEP_START: begin
            if (lv) begin
              if (count_reaches(b, CNT_W'(debounce))) step[b] = STEP_PRESSED;
            end
          end
          STEP_PRESSED: begin
            if (lv) begin
              if (count_reaches(b, long_lim)) begin
                step[b] = STEP_LONG_HELD;
                due.cmd = CMD_LONG;
              end
            end else if (count_reaches(b, CNT_W'(debounce))) begin
              step[b] = STEP_WAIT_PRESS;
            end
          end
          STEP_LONG_HELD: begin
            if (lv) begin
              due.cmd = CMD_LONG;
            end else if (count_reaches(b, CNT_W'(debounce))) begin
              step[b] = STEP_END;
            end
          end
          STEP_WAIT_PRESS: begin
            if (lv) begin
              if (count_reaches(b, CNT_W'(debounce))) step[b] = STEP_WAIT_REL;
            end else if (count_reaches(b, CNT_W'(dclick))) begin
              step[b] = STEP_END;
              due.cmd = CMD_CLICK;
            end
          end
          STEP_WAIT_REL: begin
            if (!lv) begin
              if (count_reaches(b, CNT_W'(debounce))) begin
                step[b] = STEP_END;
                due.cmd = CMD_DOUBLE;
              end
            end
          end
          // The end step and the unused encodings fall back to start.
          default: begin
            step[b] = STEP_START;
            cnt[b] = '0;
          end
        endcase
      end
      due_commands.push_back(due);
    endfunction

    function void check_result(logic [IDX_W-1:0] id, logic [CMD_W-1:0] cmd);
      gesture_t due;
      if (due_commands.size() == 0) begin
        $display("%0t: result button_id %0d command %0d arrived with nothing expected",
                 $time, id, cmd);
        errors++;
        return;
      end
      due = due_commands.pop_front();
      checked++;
      cmd_seen[cmd]++;
      if (id !== due.id) begin
        $display("%0t: button_id expected %0d, got %0d", $time, due.id, id);
        errors++;
      end
      if (cmd !== due.cmd) begin
        $display("%0t: command for button %0d expected %0d, got %0d",
                 $time, due.id, due.cmd, cmd);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IDX_W-1:0]      button_index = '0;
  logic                  level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [IDX_W-1:0]      button_id;
  logic [CMD_W-1:0]      command;

  gesture_tracker tracker = new();
  bit  idle_on = 1'b1;
  int  hold_req = 0;
  int  quiet = 0;
  int  ticks_sent = 0;
  int  settings = 0;

  button_gesture_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_index (button_index),
    .level        (level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_id    (button_id),
    .command      (command)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_tick(button_index, level);
      if (out_valid && out_ready) tracker.check_result(button_id, command);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("button_gesture_decoder_top regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    @(negedge rst);
    forever begin
      int stall;
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input logic [IDX_W-1:0] b, input logic lv);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    button_index <= b;
    level        <= lv;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.due_commands.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] deb,
                                input logic [CFG_DATA_W-1:0] dcl,
                                input logic [CFG_DATA_W-1:0] lng);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DCLICK, dcl);
    write_reg(REG_LONG, lng);
    settings++;
  endtask

  task automatic send_levels(input logic [IDX_W-1:0] b, input logic [31:0] bits,
                             input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(b, bits[i]);
  endtask

  // Press and release runs sized around the current thresholds, so that
  // gestures actually complete.
  function automatic int run_length();
    int n;
    case ($urandom_range(0, 3))
      0: n = $urandom_range(1, 3);
      1: n = tracker.debounce + $urandom_range(1, 3);
      2: n = tracker.debounce + tracker.dclick + $urandom_range(1, 4);
      default: n = tracker.debounce + tracker.long_lim + $urandom_range(1, 5);
    endcase
    return (n > 40) ? 40 : n;
  endfunction

  task automatic random_phase(input int n_ticks);
    int               run_left [NUM_BUTTONS];
    logic             run_lv   [NUM_BUTTONS];
    logic [IDX_W-1:0] hot0;
    logic [IDX_W-1:0] hot1;
    logic [IDX_W-1:0] b;
    int               pick;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      run_left[i] = 0;
      run_lv[i]   = tracker.last_lv[i];
    end
    hot0 = IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
    hot1 = IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
    repeat (n_ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_tick(IDX_W'($urandom_range(0, NUM_BUTTONS - 1)), 1'($urandom_range(0, 1)));
      end else begin
        if (pick < 80) begin
          b = pick[0] ? hot0 : hot1;
        end else begin
          b = IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
        end
        if (run_left[b] == 0) begin
          run_lv[b]   = !run_lv[b];
          run_left[b] = run_length();
        end
        send_tick(b, run_lv[b]);
        run_left[b]--;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Short thresholds: a click, a long push that repeats, a double click.
    set_thresholds(16'd1, 16'd3, 16'd4);
    send_levels(3'd0, 32'b1100000, 7);
    send_levels(3'd7, 32'b11111111000, 11);
    send_levels(3'd5, 32'b110011000, 9);
    wait_drained();

    // The result side holds off for a long stretch while ticks keep coming.
    set_thresholds(16'd2, 16'd6, 16'd10);
    hold_req = HOLD_OFF;
    random_phase(80);
    wait_drained();

    idle_on = 1'b0;
    set_thresholds(16'd0, 16'd0, 16'd0);
    random_phase(80);
    wait_drained();

    // Only the low byte of the data counts for the 8-bit thresholds.
    idle_on = 1'b1;
    set_thresholds(16'hA5FF, 16'h00FF, 16'hFFFF);
    random_phase(40);
    wait_drained();

    // The long threshold sits below the count left by debounce, so the held
    // button reports no long push.
    idle_on = 1'b0;
    set_thresholds(16'd10, 16'd20, 16'd3);
    repeat (40) send_tick(3'd2, 1'b1);
    repeat (12) send_tick(3'd2, 1'b0);
    wait_drained();

    set_thresholds(CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 12)),
                   CFG_DATA_W'($urandom_range(0, 30)));
    idle_on = 1'b1;
    hold_req = HOLD_OFF;
    random_phase(60);
    idle_on = 1'b0;
    random_phase(60);
    wait_drained();

    idle_on = 1'b1;
    set_thresholds(CFG_DATA_W'(DEBOUNCE_RESET), CFG_DATA_W'(DCLICK_RESET), LONG_RESET);
    random_phase(40);
    wait_drained();

    if (tracker.due_commands.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.due_commands.size());
      tracker.errors++;
    end
    $display("Sent %0d button ticks under %0d threshold settings, with long stalls.",
             ticks_sent, settings);
    $display("Results checked %0d: none %0d, click %0d, double %0d, long %0d.",
             tracker.checked, tracker.cmd_seen[CMD_NONE], tracker.cmd_seen[CMD_CLICK],
             tracker.cmd_seen[CMD_DOUBLE], tracker.cmd_seen[CMD_LONG]);
    if (tracker.errors == 0) begin
      $display("button_gesture_decoder_top regression: pass");
    end else begin
      $display("button_gesture_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
